// ===== sv/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// shared widths, latencies, angle constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package q2e_pkg;

    // number of cordic micro-rotations (valid range 8 to 24)
    localparam int CORDIC_STAGES = 16;

    // datapath widths
    localparam int QW    = 16;  // quaternion component
    localparam int PW    = 32;  // component product
    localparam int SUM_W = 34;  // sine / cosine terms in q.28
    localparam int CW    = 40;  // cordic x / y
    localparam int ZW    = 29;  // cordic angle in q.24
    localparam int AW    = 18;  // rounded angle in q3.13 before saturation
    localparam int SW    = 29;  // pitch sine term after clamp check
    localparam int NW    = 58;  // integer square root remainder / root

    // latencies
    localparam int ISQ_STEPS  = 29;
    localparam int ISQ_LAT    = ISQ_STEPS + 2;
    localparam int CORDIC_LAT = CORDIC_STAGES + 2;
    localparam int PIPE_DEPTH = 2 + ISQ_LAT + CORDIC_LAT;

    // angle constants
    localparam logic signed [ZW-1:0] PI_Q24      = ZW'(52707179);
    localparam logic signed [AW-1:0] PI_Q13      = AW'(25736);
    localparam logic signed [AW-1:0] HALF_PI_Q13 = AW'(12868);

    // sine / cosine terms of one quaternion
    typedef struct packed {
        logic signed [SUM_W-1:0] sinr;
        logic signed [SUM_W-1:0] cosr;
        logic signed [SUM_W-1:0] sinp;
        logic signed [SUM_W-1:0] siny;
        logic signed [SUM_W-1:0] cosy;
    } sums_t;

    // pitch status traveling beside the root
    typedef struct packed {
        logic clamp;
        logic pos;
    } pitch_flag_t;

    // round(atan(2^-i) * 2^24)
    function automatic logic signed [ZW-1:0] atan_q24(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = ZW'(13176795);
            1:       v = ZW'(7778716);
            2:       v = ZW'(4110060);
            3:       v = ZW'(2086331);
            4:       v = ZW'(1047214);
            5:       v = ZW'(524117);
            6:       v = ZW'(262123);
            7:       v = ZW'(131069);
            8:       v = ZW'(65536);
            9:       v = ZW'(32768);
            10:      v = ZW'(16384);
            11:      v = ZW'(8192);
            12:      v = ZW'(4096);
            13:      v = ZW'(2048);
            14:      v = ZW'(1024);
            15:      v = ZW'(512);
            16:      v = ZW'(256);
            17:      v = ZW'(128);
            18:      v = ZW'(64);
            19:      v = ZW'(32);
            20:      v = ZW'(16);
            21:      v = ZW'(8);
            22:      v = ZW'(4);
            23:      v = ZW'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/quaternion_to_euler_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_top
// unit quaternion in q1.14 to zyx euler angles (roll, pitch, yaw) in q3.13
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_ready with quat_w, quat_x, quat_y, quat_z;
//   one beat per quaternion
//   output channel: out_valid / out_ready with roll_angle, pitch_angle,
//   yaw_angle and pitch_clamped; one beat per input beat, in order
//   throughput: one beat per cycle sustained while out_ready stays high
//   the result path runs through the product/sum stages, the 29-step square
//   root of the pitch cosine and the pitch cordic; roll and yaw run early
//   and wait in a delay line
//   reset: clears all valid bits, the pipeline comes up empty
//   stall: when out_ready is low with a result waiting, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module quaternion_to_euler_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic               pitch_clamped
);

    localparam int AW    = q2e_pkg::AW;
    localparam int CW    = q2e_pkg::CW;
    localparam int DEPTH = q2e_pkg::PIPE_DEPTH;
    localparam int ISQ   = q2e_pkg::ISQ_LAT;
    localparam int CLAT  = q2e_pkg::CORDIC_LAT;

    logic ce;
    logic [DEPTH-1:0] vld_reg;
    q2e_pkg::sums_t sums;
    logic signed [q2e_pkg::SW-1:0] sinp_c;
    logic        [q2e_pkg::SW-1:0] root;
    q2e_pkg::pitch_flag_t flag;
    logic signed [AW-1:0] roll_raw, yaw_raw, pitch_raw, roll_d, yaw_d;
    logic signed [AW-1:0] roll_dly_reg [0:ISQ-1];
    logic signed [AW-1:0] yaw_dly_reg  [0:ISQ-1];
    q2e_pkg::pitch_flag_t flag_dly_reg [0:CLAT-1];
    q2e_pkg::pitch_flag_t flag_d;

    // global advance: move when the last stage is empty or being taken
    assign ce       = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready = ce;

    // valid bits beside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    q2e_terms u_terms (
        .clk    (clk),
        .en     (ce),
        .quat_w (quat_w),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z),
        .sums   (sums)
    );

    q2e_cordic u_roll (
        .clk   (clk),
        .en    (ce),
        .y_in  (CW'(sums.sinr)),
        .x_in  (CW'(sums.cosr)),
        .angle (roll_raw)
    );

    q2e_cordic u_yaw (
        .clk   (clk),
        .en    (ce),
        .y_in  (CW'(sums.siny)),
        .x_in  (CW'(sums.cosy)),
        .angle (yaw_raw)
    );

    q2e_isqrt u_isqrt (
        .clk      (clk),
        .en       (ce),
        .sinp     (sums.sinp),
        .sinp_out (sinp_c),
        .root     (root),
        .flag     (flag)
    );

    q2e_cordic u_pitch (
        .clk   (clk),
        .en    (ce),
        .y_in  (CW'(sinp_c)),
        .x_in  (CW'(signed'({1'b0, root}))),
        .angle (pitch_raw)
    );

    // align roll / yaw with the pitch path, and pitch flags with its cordic
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            roll_dly_reg[0] <= roll_raw;
            yaw_dly_reg[0]  <= yaw_raw;
            for (int i = 1; i < ISQ; i++)
            begin
                roll_dly_reg[i] <= roll_dly_reg[i-1];
                yaw_dly_reg[i]  <= yaw_dly_reg[i-1];
            end
            flag_dly_reg[0] <= flag;
            for (int j = 1; j < CLAT; j++)
            begin
                flag_dly_reg[j] <= flag_dly_reg[j-1];
            end
        end
    end

    assign roll_d = roll_dly_reg[ISQ-1];
    assign yaw_d  = yaw_dly_reg[ISQ-1];
    assign flag_d = flag_dly_reg[CLAT-1];

    // saturation and clamp selection on held registers
    always_comb
    begin
        if (roll_d > q2e_pkg::PI_Q13)
            roll_angle = 16'(q2e_pkg::PI_Q13);
        else if (roll_d < -q2e_pkg::PI_Q13)
            roll_angle = 16'(-q2e_pkg::PI_Q13);
        else
            roll_angle = roll_d[15:0];

        if (yaw_d > q2e_pkg::PI_Q13)
            yaw_angle = 16'(q2e_pkg::PI_Q13);
        else if (yaw_d < -q2e_pkg::PI_Q13)
            yaw_angle = 16'(-q2e_pkg::PI_Q13);
        else
            yaw_angle = yaw_d[15:0];

        if (flag_d.clamp)
            pitch_angle = flag_d.pos ? 15'(q2e_pkg::HALF_PI_Q13)
                                     : 15'(-q2e_pkg::HALF_PI_Q13);
        else if (pitch_raw > q2e_pkg::HALF_PI_Q13)
            pitch_angle = 15'(q2e_pkg::HALF_PI_Q13);
        else if (pitch_raw < -q2e_pkg::HALF_PI_Q13)
            pitch_angle = 15'(-q2e_pkg::HALF_PI_Q13);
        else
            pitch_angle = pitch_raw[14:0];

        pitch_clamped = flag_d.clamp;
    end

    assign out_valid = vld_reg[DEPTH-1];

endmodule

// ===== sv/q2e_terms.sv =====
// ----------------------------------------------------------------------------
// q2e_terms
// two stages: component products, then the five sine / cosine sums in q.28
// ----------------------------------------------------------------------------
module q2e_terms (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [q2e_pkg::QW-1:0] quat_w,
    input  logic signed [q2e_pkg::QW-1:0] quat_x,
    input  logic signed [q2e_pkg::QW-1:0] quat_y,
    input  logic signed [q2e_pkg::QW-1:0] quat_z,
    output q2e_pkg::sums_t                sums
);

    localparam int SUM_W = q2e_pkg::SUM_W;
    localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(1) <<< 28;

    logic signed [q2e_pkg::PW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg;
    logic signed [q2e_pkg::PW-1:0] zx_reg, wz_reg, xy_reg, zz_reg;
    q2e_pkg::sums_t sums_reg, sums_next;

    // product stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            wy_reg <= quat_w * quat_y;
            zx_reg <= quat_z * quat_x;
            wz_reg <= quat_w * quat_z;
            xy_reg <= quat_x * quat_y;
            zz_reg <= quat_z * quat_z;
        end
    end

    // sum stage
    always_comb
    begin
        sums_next.sinr = (SUM_W'(wx_reg) + SUM_W'(yz_reg)) <<< 1;
        sums_next.cosr = ONE_Q28 - ((SUM_W'(xx_reg) + SUM_W'(yy_reg)) <<< 1);
        sums_next.sinp = (SUM_W'(wy_reg) - SUM_W'(zx_reg)) <<< 1;
        sums_next.siny = (SUM_W'(wz_reg) + SUM_W'(xy_reg)) <<< 1;
        sums_next.cosy = ONE_Q28 - ((SUM_W'(yy_reg) + SUM_W'(zz_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sums_reg <= sums_next;
        end
    end

    assign sums = sums_reg;

endmodule

// ===== sv/q2e_isqrt.sv =====
// ----------------------------------------------------------------------------
// q2e_isqrt
// pitch cosine: clamp check, square of the sine term, then a pipelined
// restoring integer square root of 2^56 - sinp^2, one root bit per stage
// ----------------------------------------------------------------------------
module q2e_isqrt (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [q2e_pkg::SUM_W-1:0] sinp,
    output logic signed [q2e_pkg::SW-1:0]    sinp_out,
    output logic        [q2e_pkg::SW-1:0]    root,
    output q2e_pkg::pitch_flag_t             flag
);

    localparam int NW    = q2e_pkg::NW;
    localparam int SW    = q2e_pkg::SW;
    localparam int STEPS = q2e_pkg::ISQ_STEPS;
    localparam logic signed [q2e_pkg::SUM_W-1:0] ONE_Q28 = q2e_pkg::SUM_W'(1) <<< 28;
    localparam logic [NW-1:0] ONE_Q56 = NW'(1) << 56;

    typedef struct packed {
        logic        [NW-1:0] n;
        logic        [NW-1:0] r;
        logic signed [SW-1:0] s;
        q2e_pkg::pitch_flag_t f;
    } root_t;

    logic        [27:0] mag;
    logic        [27:0] hh_reg, hl_reg, ll_reg;
    logic signed [SW-1:0] sq_s_reg;
    q2e_pkg::pitch_flag_t sq_f_reg, sq_f_next;
    logic [NW-1:0] s2;
    root_t stg_reg [0:STEPS];

    // clamp check and split square
    always_comb
    begin
        sq_f_next.clamp = (sinp >= ONE_Q28) || (sinp <= -ONE_Q28);
        sq_f_next.pos   = (sinp > 0);
        mag = sinp[q2e_pkg::SUM_W-1] ? 28'(-sinp) : sinp[27:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg   <= 28'(mag[27:14]) * 28'(mag[27:14]);
            hl_reg   <= 28'(mag[27:14]) * 28'(mag[13:0]);
            ll_reg   <= 28'(mag[13:0]) * 28'(mag[13:0]);
            sq_s_reg <= sinp[SW-1:0];
            sq_f_reg <= sq_f_next;
        end
    end

    // radicand
    assign s2 = (NW'(hh_reg) << 28) + (NW'(hl_reg) << 15) + NW'(ll_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0].n <= ONE_Q56 - s2;
            stg_reg[0].r <= '0;
            stg_reg[0].s <= sq_s_reg;
            stg_reg[0].f <= sq_f_reg;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [NW-1:0] BIT = NW'(1) << (2 * (STEPS - 1 - k));
        root_t step_next;
        logic [NW-1:0] trial;

        always_comb
        begin
            step_next = stg_reg[k];
            trial     = stg_reg[k].r + BIT;
            if (stg_reg[k].n >= trial)
            begin
                step_next.n = stg_reg[k].n - trial;
                step_next.r = (stg_reg[k].r >> 1) + BIT;
            end
            else
            begin
                step_next.r = stg_reg[k].r >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg[k+1] <= step_next;
            end
        end
    end

    assign root     = stg_reg[STEPS].r[SW-1:0];
    assign sinp_out = stg_reg[STEPS].s;
    assign flag     = stg_reg[STEPS].f;

endmodule

// ===== sv/q2e_cordic.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic
// pipelined vectoring cordic atan2: quadrant fold, one micro-rotation per
// stage, then rounding to q3.13
// ----------------------------------------------------------------------------
module q2e_cordic (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [q2e_pkg::CW-1:0] y_in,
    input  logic signed [q2e_pkg::CW-1:0] x_in,
    output logic signed [q2e_pkg::AW-1:0] angle
);

    localparam int CW = q2e_pkg::CW;
    localparam int ZW = q2e_pkg::ZW;
    localparam int NS = q2e_pkg::CORDIC_STAGES;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } rot_t;

    rot_t stg_reg [0:NS];
    rot_t pre_next;
    logic signed [ZW-1:0] zr;
    logic signed [q2e_pkg::AW-1:0] angle_reg;

    // quadrant fold for negative x
    always_comb
    begin
        pre_next.zero = (x_in == '0) && (y_in == '0);
        if (x_in < 0)
        begin
            pre_next.z = (y_in >= 0) ? q2e_pkg::PI_Q24 : -q2e_pkg::PI_Q24;
            pre_next.x = -x_in;
            pre_next.y = -y_in;
        end
        else
        begin
            pre_next.z = '0;
            pre_next.x = x_in;
            pre_next.y = y_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0] <= pre_next;
        end
    end

    // micro-rotations
    for (genvar i = 0; i < NS; i++)
    begin : g_rot
        localparam logic signed [ZW-1:0] ATAN = q2e_pkg::atan_q24(i);
        rot_t rot_next;

        always_comb
        begin
            rot_next = stg_reg[i];
            if (stg_reg[i].y > 0)
            begin
                rot_next.x = stg_reg[i].x + (stg_reg[i].y >>> i);
                rot_next.y = stg_reg[i].y - (stg_reg[i].x >>> i);
                rot_next.z = stg_reg[i].z + ATAN;
            end
            else
            begin
                rot_next.x = stg_reg[i].x - (stg_reg[i].y >>> i);
                rot_next.y = stg_reg[i].y + (stg_reg[i].x >>> i);
                rot_next.z = stg_reg[i].z - ATAN;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg[i+1] <= rot_next;
            end
        end
    end

    // round q.24 to q3.13
    assign zr = (stg_reg[NS].z + ZW'(1024)) >>> 11;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= stg_reg[NS].zero ? '0 : zr[q2e_pkg::AW-1:0];
        end
    end

    assign angle = angle_reg;

endmodule

// ===== tb/sv/q2e_checker.sv =====
// ----------------------------------------------------------------------------
// q2e_checker
// watches both channels, predicts roll, pitch and yaw for each accepted
// quaternion and compares every output beat with the oldest prediction
// ----------------------------------------------------------------------------
module q2e_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] roll_angle,
    input  logic signed [14:0] pitch_angle,
    input  logic signed [15:0] yaw_angle,
    input  logic               pitch_clamped,
    output int                 errors,
    output int                 pending,
    output int                 n_clamped,
    output int                 n_results
);

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamp;
    } euler_t;

    localparam longint ONE_Q28 = 64'sd1 <<< 28;

    euler_t angle_fifo[$];

    // vectoring cordic arctangent, q3.13 before saturation
    function automatic longint vector_angle(input longint yv, input longint xv);
        longint xa, ya, za, dx, dy;
        xa = xv;
        ya = yv;
        za = 0;
        if (xa == 0 && ya == 0)
            return 0;
        if (xa < 0)
        begin
            za = (ya >= 0) ? 64'sd52707179 : -64'sd52707179;
            xa = -xa;
            ya = -ya;
        end
        for (int i = 0; i < q2e_pkg::CORDIC_STAGES && i < 24; i++)
        begin
            dx = ya >>> i;
            dy = xa >>> i;
            if (ya > 0)
            begin
                xa += dx;
                ya -= dy;
                za += longint'(q2e_pkg::atan_q24(i));
            end
            else
            begin
                xa -= dx;
                ya += dy;
                za -= longint'(q2e_pkg::atan_q24(i));
            end
        end
        return (za + 1024) >>> 11;
    endfunction

    function automatic longint clip(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint root_floor(input longint unsigned n);
        longint unsigned r, b, m;
        m = n;
        r = 0;
        b = 64'd1 << 62;
        while (b > m)
            b >>= 2;
        while (b != 0)
        begin
            if (m >= r + b)
            begin
                m -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic euler_t predict_euler(input longint w, input longint x,
                                             input longint y, input longint z);
        euler_t e;
        longint sinr, cosr, sinp, siny, cosy, c;
        sinr = 2 * (w * x + y * z);
        cosr = ONE_Q28 - 2 * (x * x + y * y);
        sinp = 2 * (w * y - z * x);
        siny = 2 * (w * z + x * y);
        cosy = ONE_Q28 - 2 * (y * y + z * z);
        e.roll = 16'(clip(vector_angle(sinr, cosr), 25736));
        e.yaw  = 16'(clip(vector_angle(siny, cosy), 25736));
        if (sinp >= ONE_Q28 || sinp <= -ONE_Q28)
        begin
            e.pitch = (sinp > 0) ? 15'sd12868 : -15'sd12868;
            e.clamp = 1'b1;
        end
        else
        begin
            c = root_floor((64'd1 << 56) - longint'(sinp * sinp));
            e.pitch = 15'(clip(vector_angle(sinp, c), 12868));
            e.clamp = 1'b0;
        end
        return e;
    endfunction

    // predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n)
    begin
        euler_t exp_e;
        if (!rst_n)
        begin
            errors    <= 0;
            n_clamped <= 0;
            n_results <= 0;
            angle_fifo.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                angle_fifo.push_back(predict_euler(quat_w, quat_x, quat_y, quat_z));
            if (out_valid && out_ready)
            begin
                n_results <= n_results + 1;
                if (pitch_clamped)
                    n_clamped <= n_clamped + 1;
                if (angle_fifo.size() == 0)
                begin
                    if (errors < 10)
                        $display("error: unexpected output beat at %0t", $realtime);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_e = angle_fifo.pop_front();
                    if (exp_e.roll !== roll_angle || exp_e.pitch !== pitch_angle ||
                        exp_e.yaw !== yaw_angle || exp_e.clamp !== pitch_clamped)
                    begin
                        if (errors < 10)
                            $display({"mismatch: exp r=%0d p=%0d y=%0d c=%0b",
                                      " got r=%0d p=%0d y=%0d c=%0b"},
                                     exp_e.roll, exp_e.pitch, exp_e.yaw, exp_e.clamp,
                                     roll_angle, pitch_angle, yaw_angle, pitch_clamped);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    assign pending = angle_fifo.size();

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stimulus for quaternion_to_euler_top: directed corner quaternions, then
// random unit and raw quaternions with random idling on both channels
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_RANDOM  = 800;
    localparam int CYCLE_MAX = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
    int                 errors, pending, n_clamped, n_results;
    int                 cycle_cnt;
    bit                 calm;

    quaternion_to_euler_top u_top (.*);

    q2e_checker u_chk (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_MAX)
            begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // receiver stalls in random bursts
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 18);
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // one input beat, with an optional idle burst before it
    task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_w   <= w;
        quat_x   <= x;
        quat_y   <= y;
        quat_z   <= z;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // random quaternion of roughly unit norm, with random signs
    task automatic send_unit_quat();
        int a, b, c, d;
        real n;
        a = $urandom_range(0, 16384) - 8192;
        b = $urandom_range(0, 16384) - 8192;
        c = $urandom_range(0, 16384) - 8192;
        d = $urandom_range(0, 16384) - 8192;
        n = $sqrt(real'(a * a + b * b + c * c + d * d));
        if (n < 1.0)
            n = 1.0;
        send_quat(16'($rtoi(a * 16384.0 / n)), 16'($rtoi(b * 16384.0 / n)),
                  16'($rtoi(c * 16384.0 / n)), 16'($rtoi(d * 16384.0 / n)));
    endtask

    initial
    begin
        in_valid = 1'b0;
        quat_w   = '0;
        quat_x   = '0;
        quat_y   = '0;
        quat_z   = '0;
        calm     = 1'b0;
        rst_n    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: identity, axis turns, zero vector, positive clamp,
        // gimbal lock, negative cosine, field extremes
        send_quat(16384, 0, 0, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(0, 0, 0, 0);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(11585, 11585, 11585, -11585);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(8192, -8192, -8192, 8192);
        send_quat(0, 11585, 0, 11585);
        send_quat(0, -11585, 0, -11585);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
        send_quat(-16384, 16384, -16384, 16384);
        send_quat(16383, 1, 0, 0);
        send_quat(0, 0, 16384, 1);

        // random: mostly unit quaternions, some raw words
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i > N_RANDOM - 100)
                calm = 1'b1;
            if ($urandom_range(0, 4) == 0)
                send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_unit_quat();
        end
        in_valid <= 1'b0;

        // drain, then let the pipeline settle
        while (pending != 0)
            @(posedge clk);
        repeat (q2e_pkg::PIPE_DEPTH + 10) @(posedge clk);

        $display("covered %0d quaternions, %0d with pitch clamped",
                 n_results, n_clamped);
        $display("random idling on both sides, then a stretch with none");
        if (errors == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
sv/q2e_pkg.sv
sv/q2e_terms.sv
sv/q2e_isqrt.sv
sv/q2e_cordic.sv
sv/quaternion_to_euler_top.sv
tb/sv/q2e_checker.sv
tb/sv/tb_top.sv
